// File: rtl/slx_pkg.sv
// shared types, constants and byte classification for the source lexer
package slx_pkg;

    // default counter widths
    localparam int OFFSET_BITS_DEF = 32;
    localparam int LINE_BITS_DEF   = 32;

    // result queue depth, two free entries are needed to take a request
    localparam int QDEPTH = 4;

    // token kinds
    localparam logic [4:0] TK_EOF    = 5'd0;
    localparam logic [4:0] TK_INT    = 5'd1;
    localparam logic [4:0] TK_DBL    = 5'd2;
    localparam logic [4:0] TK_STR    = 5'd3;
    localparam logic [4:0] TK_IDENT  = 5'd4;
    localparam logic [4:0] TK_LPAREN = 5'd5;
    localparam logic [4:0] TK_RPAREN = 5'd6;
    localparam logic [4:0] TK_LBRACE = 5'd7;
    localparam logic [4:0] TK_RBRACE = 5'd8;
    localparam logic [4:0] TK_LBRACK = 5'd9;
    localparam logic [4:0] TK_RBRACK = 5'd10;
    localparam logic [4:0] TK_SEMI   = 5'd11;
    localparam logic [4:0] TK_COMMA  = 5'd12;
    localparam logic [4:0] TK_DOT    = 5'd13;
    localparam logic [4:0] TK_PLUS   = 5'd14;
    localparam logic [4:0] TK_STAR   = 5'd15;
    localparam logic [4:0] TK_COLON  = 5'd16;
    localparam logic [4:0] TK_BANG   = 5'd17;
    localparam logic [4:0] TK_ASSIGN = 5'd19;
    localparam logic [4:0] TK_LT     = 5'd21;
    localparam logic [4:0] TK_GT     = 5'd23;
    localparam logic [4:0] TK_MINUS  = 5'd25;
    localparam logic [4:0] TK_SLASH  = 5'd27;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_UNTERM  = 2'd2;

    // source bytes with a meaning of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    // input request
    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } t_in_item;

    // result
    typedef struct packed {
        logic [4:0]  token_kind;
        logic [31:0] start_offset;
        logic [31:0] length;
        logic [31:0] line_number;
        logic [1:0]  error_code;
        logic        last;
    } t_out_item;

    // results of one request handed to the queue
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  r0;
        t_out_item  r1;
    } t_push;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
               ((c >= CH_UC_A) && (c <= CH_UC_Z)) || (c == CH_UNDER);
    endfunction

    // single-byte punctuation, TK_EOF when the byte is none of them
    function automatic logic [4:0] plain_punct(logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_LPAR:  k = TK_LPAREN;
            CH_RPAR:  k = TK_RPAREN;
            CH_LBRC:  k = TK_LBRACE;
            CH_RBRC:  k = TK_RBRACE;
            CH_LBRK:  k = TK_LBRACK;
            CH_RBRK:  k = TK_RBRACK;
            CH_SEMI:  k = TK_SEMI;
            CH_COMMA: k = TK_COMMA;
            CH_DOT:   k = TK_DOT;
            CH_PLUS:  k = TK_PLUS;
            CH_STAR:  k = TK_STAR;
            CH_COLON: k = TK_COLON;
            default:  k = TK_EOF;
        endcase
        return k;
    endfunction

    // clamp a counter value to the 32-bit result field
    function automatic logic [31:0] clamp32(logic [63:0] v);
        return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

// File: rtl/slx_scan_core.sv
// scanner mode machine, offset and line counters, result formation
module slx_scan_core #(
    parameter int OFFSET_BITS = slx_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = slx_pkg::LINE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  slx_pkg::t_in_item i_item,
    output slx_pkg::t_push    o_push
);

    typedef enum logic [3:0] {
        M_IDLE, M_INT, M_DBL, M_IDENT, M_STR, M_SLASH, M_COMMENT,
        M_BANG, M_EQ, M_LT, M_GT, M_MINUS, M_ERROR
    } t_mode;

    localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [LINE_BITS-1:0]   r_line, n_line;

    logic [7:0]             c;
    logic                   eoi;
    logic                   used;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic [OFFSET_BITS-1:0] span;

    // pending token closed by this request
    logic                   p_v;
    logic [4:0]             p_kind;
    logic [OFFSET_BITS-1:0] p_len;
    logic [1:0]             p_err;

    // token or marker at the current byte position
    logic                   t_v;
    logic [4:0]             t_kind;
    logic                   t_len1;
    logic [1:0]             t_err;

    slx_pkg::t_out_item     p_item, t_item;

    // one-byte kind of a pending operator mode
    function automatic logic [4:0] op_single(t_mode m);
        logic [4:0] k;
        case (m)
            M_BANG:  k = slx_pkg::TK_BANG;
            M_EQ:    k = slx_pkg::TK_ASSIGN;
            M_LT:    k = slx_pkg::TK_LT;
            M_GT:    k = slx_pkg::TK_GT;
            M_MINUS: k = slx_pkg::TK_MINUS;
            default: k = slx_pkg::TK_SLASH;
        endcase
        return k;
    endfunction

    assign c        = i_item.char_code;
    assign eoi      = i_item.kind || (c == slx_pkg::CH_NUL);
    assign pos_inc  = (r_pos == OFS_MAX) ? r_pos : r_pos + OFFSET_BITS'(1);
    assign line_inc = (r_line == LINE_MAX) ? r_line : r_line + LINE_BITS'(1);
    assign span     = (r_pos >= r_start) ? r_pos - r_start : '0;

    // next state and results of one request
    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_pos   = pos_inc;
        n_line  = r_line;
        used    = 1'b0;
        p_v     = 1'b0;
        p_kind  = slx_pkg::TK_EOF;
        p_len   = span;
        p_err   = slx_pkg::ERR_NONE;
        t_v     = 1'b0;
        t_kind  = slx_pkg::TK_EOF;
        t_len1  = 1'b1;
        t_err   = slx_pkg::ERR_NONE;
        if (eoi) begin
            // flush the pending token, then the end marker, then back to reset
            case (r_mode)
                M_INT: begin
                    p_v    = 1'b1;
                    p_kind = slx_pkg::TK_INT;
                end
                M_DBL: begin
                    p_v    = 1'b1;
                    p_kind = slx_pkg::TK_DBL;
                end
                M_IDENT: begin
                    p_v    = 1'b1;
                    p_kind = slx_pkg::TK_IDENT;
                end
                M_STR: begin
                    p_v   = 1'b1;
                    p_err = slx_pkg::ERR_UNTERM;
                end
                M_SLASH, M_BANG, M_EQ, M_LT, M_GT, M_MINUS: begin
                    p_v    = 1'b1;
                    p_kind = op_single(r_mode);
                    p_len  = OFFSET_BITS'(1);
                end
                default: begin
                    p_v = 1'b0;
                end
            endcase
            t_v     = 1'b1;
            t_len1  = 1'b0;
            n_mode  = M_IDLE;
            n_start = '0;
            n_pos   = '0;
            n_line  = LINE_BITS'(1);
        end else begin
            // continue or close the token in progress
            case (r_mode)
                M_ERROR: begin
                    used = 1'b1;
                end
                M_INT: begin
                    if (slx_pkg::is_digit(c)) begin
                        used = 1'b1;
                    end else if (c == slx_pkg::CH_DOT) begin
                        used   = 1'b1;
                        n_mode = M_DBL;
                    end else begin
                        p_v    = 1'b1;
                        p_kind = slx_pkg::TK_INT;
                    end
                end
                M_DBL: begin
                    if (slx_pkg::is_digit(c)) begin
                        used = 1'b1;
                    end else begin
                        p_v    = 1'b1;
                        p_kind = slx_pkg::TK_DBL;
                    end
                end
                M_IDENT: begin
                    if (slx_pkg::is_alpha(c) || slx_pkg::is_digit(c)) begin
                        used = 1'b1;
                    end else begin
                        p_v    = 1'b1;
                        p_kind = slx_pkg::TK_IDENT;
                    end
                end
                M_STR: begin
                    used = 1'b1;
                    if (c == slx_pkg::CH_QUOTE) begin
                        p_v    = 1'b1;
                        p_kind = slx_pkg::TK_STR;
                        n_mode = M_IDLE;
                    end
                end
                M_COMMENT: begin
                    used = 1'b1;
                    if (c == slx_pkg::CH_LF) begin
                        n_line = line_inc;
                        n_mode = M_IDLE;
                    end
                end
                M_SLASH: begin
                    if (c == slx_pkg::CH_SLASH) begin
                        used   = 1'b1;
                        n_mode = M_COMMENT;
                    end else begin
                        p_v    = 1'b1;
                        p_kind = slx_pkg::TK_SLASH;
                        p_len  = OFFSET_BITS'(1);
                    end
                end
                M_BANG, M_EQ, M_LT, M_GT, M_MINUS: begin
                    p_v = 1'b1;
                    if (((r_mode == M_MINUS) && (c == slx_pkg::CH_GT)) ||
                        ((r_mode != M_MINUS) && (c == slx_pkg::CH_EQ))) begin
                        used   = 1'b1;
                        p_kind = op_single(r_mode) + 5'd1;
                        p_len  = OFFSET_BITS'(2);
                        n_mode = M_IDLE;
                    end else begin
                        p_kind = op_single(r_mode);
                        p_len  = OFFSET_BITS'(1);
                    end
                end
                default: begin
                    used = 1'b0;
                end
            endcase

            // byte seen between tokens
            if (!used) begin
                n_mode = M_IDLE;
                if (c inside {slx_pkg::CH_SPACE, slx_pkg::CH_TAB, slx_pkg::CH_CR}) begin
                    n_mode = M_IDLE;
                end else if (c == slx_pkg::CH_LF) begin
                    n_line = line_inc;
                end else begin
                    n_start = r_pos;
                    if (slx_pkg::is_digit(c)) begin
                        n_mode = M_INT;
                    end else if (slx_pkg::is_alpha(c)) begin
                        n_mode = M_IDENT;
                    end else if (c == slx_pkg::CH_QUOTE) begin
                        n_start = pos_inc;
                        n_mode  = M_STR;
                    end else if (c == slx_pkg::CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (c == slx_pkg::CH_BANG) begin
                        n_mode = M_BANG;
                    end else if (c == slx_pkg::CH_EQ) begin
                        n_mode = M_EQ;
                    end else if (c == slx_pkg::CH_LT) begin
                        n_mode = M_LT;
                    end else if (c == slx_pkg::CH_GT) begin
                        n_mode = M_GT;
                    end else if (c == slx_pkg::CH_MINUS) begin
                        n_mode = M_MINUS;
                    end else if (slx_pkg::plain_punct(c) != slx_pkg::TK_EOF) begin
                        t_v    = 1'b1;
                        t_kind = slx_pkg::plain_punct(c);
                    end else begin
                        t_v    = 1'b1;
                        t_err  = slx_pkg::ERR_UNKNOWN;
                        n_mode = M_ERROR;
                    end
                end
            end
        end
    end

    // result formation
    always_comb begin
        p_item.token_kind   = p_kind;
        p_item.start_offset = slx_pkg::clamp32(64'(r_start));
        p_item.length       = slx_pkg::clamp32(64'(p_len));
        p_item.line_number  = slx_pkg::clamp32(64'(r_line));
        p_item.error_code   = p_err;
        p_item.last         = !t_v;
        t_item.token_kind   = t_kind;
        t_item.start_offset = slx_pkg::clamp32(64'(r_pos));
        t_item.length       = {31'd0, t_len1};
        t_item.line_number  = slx_pkg::clamp32(64'(r_line));
        t_item.error_code   = t_err;
        t_item.last         = 1'b1;
        o_push.cnt = i_take ? ({1'b0, p_v} + {1'b0, t_v}) : 2'd0;
        o_push.r0  = p_v ? p_item : t_item;
        o_push.r1  = t_item;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_line  <= LINE_BITS'(1);
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_line  <= n_line;
        end
    end

    // end of input always leaves the reset state behind it
    a_eoi_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && eoi) |=> (r_mode == M_IDLE && r_pos == '0 &&
                             r_line == LINE_BITS'(1)))
        else $error("scanner state not cleared after end of input");

    // a request never makes more than two results
    a_max_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.cnt != 2'd3)
        else $error("more than two results for one request");

    // exactly the final result of a request carries last
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt != 2'd0) |->
            ((o_push.cnt == 2'd1 && o_push.r0.last) ||
             (o_push.cnt == 2'd2 && o_push.r1.last && !o_push.r0.last)))
        else $error("last flag misplaced");

endmodule

// File: rtl/slx_result_fifo.sv
// result queue taking up to two results per cycle and giving one unless stalled
module slx_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slx_pkg::t_push     i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output slx_pkg::t_out_item o_item
);

    localparam int DEPTH  = slx_pkg::QDEPTH;
    localparam int PW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);

    slx_pkg::t_out_item r_mem [DEPTH];
    logic [PW-1:0]      r_wr, r_rd;
    logic [CW-1:0]      r_count;
    logic               pop;
    logic [PW-1:0]      wr_next;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign pop     = o_valid && !i_stall;
    assign wr_next = r_wr + PW'(1);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.r1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_push.cnt);
            r_rd    <= r_rd + PW'(pop);
            r_count <= r_count + CW'(i_push.cnt) - CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (r_count <= CW'(DEPTH - 2)))
        else $error("results pushed without two free entries");

    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!pop && i_push.cnt == 2'd0) |=> $stable(r_count))
        else $error("queue count moved with no push or pop");

endmodule

// File: rtl/source_lexer_unit.sv
// source lexer top level: byte requests in, token results out
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+---------------------
//  in      | in        | i_in_valid / o_in_stall       | i_in_item  (t_in_item)
//  out     | out       | o_out_valid / i_out_stall     | o_out_item (t_out_item)
//
// one byte request is taken per cycle while the result queue has two free entries
// results are registered in the result queue, one result leaves per cycle unless i_out_stall is high
// a request that closes a token and emits another gives two results
// reset is synchronous and active low; it returns the scanner to idle, line 1
// a stalled output fills the four-entry result queue; o_in_stall rises once
// fewer than two entries are free
module source_lexer_unit #(
    parameter int OFFSET_BITS = slx_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = slx_pkg::LINE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  slx_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output slx_pkg::t_out_item o_out_item
);

    logic           room;
    logic           take;
    slx_pkg::t_push push;

    assign o_in_stall = !room;
    assign take       = i_in_valid && room;

    // scanner
    slx_scan_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in_item),
        .o_push  (push)
    );

    // result queue
    slx_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule
